[rtl/core/gcd_pkg.sv]
// Shared constants and helper functions of the great-circle distance unit.
package gcd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int TAB_LEN       = 32;
  localparam int SQRT_STEPS    = 32;
  localparam int ANGLE_W       = 34;
  localparam int PROD_W        = 2 * ANGLE_W;

  localparam logic signed [ANGLE_W-1:0] FULL_TURN_Q24    = 34'sd6039797760;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN_Q24    = 34'sd3019898880;
  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN_Q24 = 34'sd1509949440;
  localparam logic        [29:0]        DEG2RAD_K        = 30'd599690565;
  localparam logic signed [ANGLE_W-1:0] GAIN_INV_Q30     = 34'sd652032874;
  localparam logic        [30:0]        ONE_Q30          = 31'd1073741824;
  localparam logic        [23:0]        RADIUS_RESET     = 24'd6378137;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [ANGLE_W-1:0] atan_q30(input int unsigned i);
    logic [29:0] v;
    unique case (i)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd7;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return {4'd0, v};
  endfunction

  // Round a Q60 product back to Q30: round the magnitude, restore the sign.
  function automatic logic signed [ANGLE_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    logic signed [ANGLE_W-1:0] rs;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r   = (mag + (PROD_W'(1) << 29)) >> 30;
    rs  = ANGLE_W'(r);
    return p[PROD_W-1] ? -rs : rs;
  endfunction

endpackage

[rtl/core/gcd_rotate.sv]
// Pipelined CORDIC rotator: sine and cosine of an angle in degrees at 2^-24.
module gcd_rotate import gcd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      valid_o,
  output logic signed [ANGLE_W-1:0] sin_o,
  output logic signed [ANGLE_W-1:0] cos_o
);

  logic signed [ANGLE_W-1:0] red_d, red_q;
  logic                      va_q, vb_q, vc_q;
  logic signed [ANGLE_W-1:0] fold;
  logic                      fold_neg;
  logic [30:0]               mag_d, mag_q;
  logic                      sgn_d, sgn_q, sgn_c_q;
  logic                      nb_d, nb_q, nc_q;
  logic [60:0]               prod_q;
  logic [31:0]               zr;
  logic signed [ANGLE_W-1:0] z0;

  logic signed [ANGLE_W-1:0] x_q [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] z_q [CORDIC_STAGES+1];
  logic                      n_q [CORDIC_STAGES+1];
  logic                      v_q [CORDIC_STAGES+1];

  // reduce into (-180,180]
  always_comb begin
    if (angle_i > HALF_TURN_Q24) begin
      red_d = angle_i - FULL_TURN_Q24;
    end else if (angle_i <= -HALF_TURN_Q24) begin
      red_d = angle_i + FULL_TURN_Q24;
    end else begin
      red_d = angle_i;
    end
  end

  // fold into [-90,90]
  always_comb begin
    fold_neg = 1'b0;
    if (red_q > QUARTER_TURN_Q24) begin
      fold     = red_q - HALF_TURN_Q24;
      fold_neg = 1'b1;
    end else if (red_q < -QUARTER_TURN_Q24) begin
      fold     = red_q + HALF_TURN_Q24;
      fold_neg = 1'b1;
    end else begin
      fold = red_q;
    end
    sgn_d = fold[ANGLE_W-1];
    mag_d = sgn_d ? 31'(-fold) : 31'(fold);
    nb_d  = fold_neg;
  end

  always_comb begin
    zr = 32'((prod_q + (61'(1) << 28)) >> 29);
    z0 = sgn_c_q ? -ANGLE_W'(zr) : ANGLE_W'(zr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      va_q   <= valid_i;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      v_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d;
      mag_q   <= mag_d;
      sgn_q   <= sgn_d;
      nb_q    <= nb_d;
      prod_q  <= 61'(mag_q) * 61'(DEG2RAD_K);
      sgn_c_q <= sgn_q;
      nc_q    <= nb_q;
      x_q[0]  <= GAIN_INV_Q30;
      y_q[0]  <= '0;
      z_q[0]  <= z0;
      n_q[0]  <= nc_q;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [ANGLE_W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= n_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end
      end
    end
  end

  assign valid_o = v_q[CORDIC_STAGES];
  assign sin_o   = n_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
  assign cos_o   = n_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];

endmodule

[rtl/core/gcd_haver.sv]
// Haversine term a = sin^2(dlat/2) + cos(lat_a)cos(lat_b)sin^2(dlon/2), clamped to [0,1].
module gcd_haver import gcd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [ANGLE_W-1:0] sin_lat_i,
  input  logic signed [ANGLE_W-1:0] sin_lon_i,
  input  logic signed [ANGLE_W-1:0] cos_a_i,
  input  logic signed [ANGLE_W-1:0] cos_b_i,
  output logic                      valid_o,
  output logic [30:0]               a_o,
  output logic [30:0]               one_minus_a_o
);

  logic                      v1_q, v2_q, v3_q, v4_q;
  logic signed [PROD_W-1:0]  p_ll_q, p_oo_q, p_cc_q, p_m_q;
  logic signed [ANGLE_W-1:0] sl2_q, so2_q, cc_q, sl2_dly_q;
  logic signed [ANGLE_W:0]   sum;
  logic [30:0]               a_d, a_q, oma_q;

  always_comb begin
    sum = (ANGLE_W+1)'(sl2_dly_q) + (ANGLE_W+1)'(round_q30(p_m_q));
    if (sum < 0) begin
      a_d = '0;
    end else if (sum > (ANGLE_W+1)'(ONE_Q30)) begin
      a_d = ONE_Q30;
    end else begin
      a_d = 31'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ll_q    <= PROD_W'(sin_lat_i) * PROD_W'(sin_lat_i);
      p_oo_q    <= PROD_W'(sin_lon_i) * PROD_W'(sin_lon_i);
      p_cc_q    <= PROD_W'(cos_a_i) * PROD_W'(cos_b_i);
      sl2_q     <= round_q30(p_ll_q);
      so2_q     <= round_q30(p_oo_q);
      cc_q      <= round_q30(p_cc_q);
      p_m_q     <= PROD_W'(cc_q) * PROD_W'(so2_q);
      sl2_dly_q <= sl2_q;
      a_q       <= a_d;
      oma_q     <= ONE_Q30 - a_d;
    end
  end

  assign valid_o       = v4_q;
  assign a_o           = a_q;
  assign one_minus_a_o = oma_q;

endmodule

[rtl/core/gcd_isqrt.sv]
// Pipelined floor square root of a Q30 value, one result bit per stage.
module gcd_isqrt import gcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] value_i,
  output logic        valid_o,
  output logic [30:0] root_o
);

  logic [63:0] n_q [SQRT_STEPS+1];
  logic [63:0] r_q [SQRT_STEPS+1];
  logic        v_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= {3'd0, value_i, 30'd0};
      r_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (2 * (SQRT_STEPS - 1) - 2 * k);
    logic [63:0] trial;
    assign trial = r_q[k] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_q[k] >= trial) begin
          n_q[k+1] <= n_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + Bit;
        end else begin
          n_q[k+1] <= n_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS];
  assign root_o  = r_q[SQRT_STEPS][30:0];

endmodule

[rtl/core/gcd_vector.sv]
// Pipelined CORDIC vectoring: first-quadrant atan2(y, x) in Q30, clamped at zero.
module gcd_vector import gcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] y_i,
  input  logic [30:0] x_i,
  output logic        valid_o,
  output logic [31:0] theta_o
);

  logic signed [ANGLE_W-1:0] x_q [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] z_q [CORDIC_STAGES+1];
  logic                      v_q [CORDIC_STAGES+1];
  logic                      vt_q;
  logic [31:0]               theta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
      vt_q   <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      vt_q   <= v_q[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= ANGLE_W'(x_i);
      y_q[0]  <= ANGLE_W'(y_i);
      z_q[0]  <= '0;
      theta_q <= z_q[CORDIC_STAGES][ANGLE_W-1] ? 32'd0 : 32'(z_q[CORDIC_STAGES]);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [ANGLE_W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end
      end
    end
  end

  assign valid_o = vt_q;
  assign theta_o = theta_q;

endmodule

[rtl/core/great_circle_distance_unit.sv]
// Great-circle distance unit: top level of the haversine distance pipeline.
//
// Takes a request of two points (latitude/longitude, degrees at 2^-23) and returns the
// haversine distance in sixteenths of a metre for the sphere radius held in the
// configuration register (metres, reset 6378137). The block is one fully pipelined
// datapath: unless a result waits untaken at the output, a new request enters every
// cycle and one result leaves every cycle. A request passes through angle reduction
// and rotator, haversine products, square roots, vectoring and radius scaling, in
// that order. The whole pipe advances as one unit; when the output register holds a
// result that is not taken, every stage holds and in_ready_o drops. Write the radius
// only while the pipe is empty.
module great_circle_distance_unit import gcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        distance_q4_o
);

  logic                      en;
  logic [23:0]               radius_q;
  logic signed [ANGLE_W-1:0] lat_a_ext, lat_b_ext;
  logic signed [ANGLE_W-1:0] dlat, dlon, lat_a2, lat_b2;
  logic                      rot_valid, hav_valid, sqrt_valid, vec_valid;
  logic signed [ANGLE_W-1:0] sin_lat, sin_lon, cos_a, cos_b;
  logic [30:0]               a_val, oma_val, root_a, root_oma;
  logic [31:0]               theta;
  logic                      vp_q, out_valid_q;
  logic [55:0]               prod_q;
  logic [56:0]               rounded;
  logic [31:0]               dist_q;

  // One global advance: hold every stage while the result waits.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // A difference at 2^-23 is its own half at 2^-24; a latitude doubles into 2^-24.
  assign lat_a_ext = ANGLE_W'(lat_a_i);
  assign lat_b_ext = ANGLE_W'(lat_b_i);
  assign dlat      = lat_b_ext - lat_a_ext;
  assign dlon      = ANGLE_W'(lon_b_i) - ANGLE_W'(lon_a_i);
  assign lat_a2    = {lat_a_ext[ANGLE_W-2:0], 1'b0};
  assign lat_b2    = {lat_b_ext[ANGLE_W-2:0], 1'b0};

  gcd_rotate u_rot_dlat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .angle_i(dlat),
    .valid_o(rot_valid), .sin_o(sin_lat), .cos_o()
  );

  gcd_rotate u_rot_dlon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .angle_i(dlon),
    .valid_o(), .sin_o(sin_lon), .cos_o()
  );

  gcd_rotate u_rot_lat_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .angle_i(lat_a2),
    .valid_o(), .sin_o(), .cos_o(cos_a)
  );

  gcd_rotate u_rot_lat_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .angle_i(lat_b2),
    .valid_o(), .sin_o(), .cos_o(cos_b)
  );

  gcd_haver u_haver (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rot_valid),
    .sin_lat_i(sin_lat), .sin_lon_i(sin_lon), .cos_a_i(cos_a), .cos_b_i(cos_b),
    .valid_o(hav_valid), .a_o(a_val), .one_minus_a_o(oma_val)
  );

  gcd_isqrt u_sqrt_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(hav_valid), .value_i(a_val),
    .valid_o(sqrt_valid), .root_o(root_a)
  );

  gcd_isqrt u_sqrt_oma (
    .clk_i, .rst_ni, .en_i(en), .valid_i(hav_valid), .value_i(oma_val),
    .valid_o(), .root_o(root_oma)
  );

  gcd_vector u_vector (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sqrt_valid), .y_i(root_a), .x_i(root_oma),
    .valid_o(vec_valid), .theta_o(theta)
  );

  // d = (R * theta + 2^24) >> 25. A 24-bit radius times a theta below pi keeps the
  // rounded value inside 32 bits, so taking bits 56:25 of it drops nothing.
  assign rounded = 57'(prod_q) + (57'(1) << 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vp_q        <= vec_valid;
      out_valid_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 56'(radius_q) * 56'(theta);
      dist_q <= rounded[56:25];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_q4_o = dist_q;

endmodule
